[rtl/sstf_pkg.sv]
// Package for the shortest-seek-time-first disk request scheduler.
// Holds the beat types, event and result codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package sstf_pkg;

  localparam int unsigned TrackW   = 10;
  localparam int unsigned ReqW     = 4;
  localparam int unsigned CountW   = 5;
  localparam int unsigned CfgDataW = 5;
  localparam int unsigned CfgIdxW  = 1;

  // Event codes carried in an input beat.
  typedef enum logic [0:0] {
    OP_SUBMIT = 1'b0,
    OP_DONE   = 1'b1
  } op_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_SERVICE    = 2'd0,
    KIND_NO_SERVICE = 2'd1,
    KIND_REJECTED   = 2'd2
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_QUEUE_CAPACITY  = 1'b0,
    CFG_REQUESTER_TOTAL = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    op_e               op;
    logic [ReqW-1:0]   requester;
    logic [TrackW-1:0] track;
  } in_t;

  typedef struct packed {
    kind_e             kind;
    logic [ReqW-1:0]   served_requester;
    logic [TrackW-1:0] served_track;
    logic              last;
  } result_t;

endpackage

[rtl/sstf_disk_request_scheduler.sv]
// Top level of the shortest-seek-time-first disk request scheduler.
// Depends on sstf_pkg and sstf_ram.
`timescale 1ns / 1ps

// Usage.
// An event beat (in_i) is taken at a rising edge where start_i is high and
// busy_o is low. A submit beat parks a track request in the requester's slot;
// a done beat lowers the active requester count. After each event the block
// serves the nearest pending request (ties to the lowest requester) as long as
// the queue is not empty and holds at least min(active count, queue capacity) requests.
// Each result beat is shown on result_o for exactly one cycle, flagged by
// result_valid_o, and the final beat of an event has last set. The receiver
// cannot stall; each service is held inside until it is known whether it is the last.
// A rejected submit gives its single result in the cycle after the accepting
// edge and the block stays ready. Any other event keeps busy_o high through
// the check, scan and finish states, and every service sweeps all slots of
// the track RAM through its one read port, one slot per cycle, with a
// registered read.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at the
// edge; writing the requester total also reloads the active count.
// Reset clears all pending slots, the head position and the queue count, and
// sets the capacity and active count to 16. The track RAM is not cleared: a
// slot's track is only used while its pending bit is set.
module sstf_disk_request_scheduler #(
  parameter int unsigned MAX_REQUESTERS = 16,
  parameter int unsigned TRACK_LIMIT    = 1000
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  sstf_pkg::in_t                   in_i,
  output logic                            result_valid_o,
  output sstf_pkg::result_t               result_o,
  input  logic                            cfg_we_i,
  input  logic [sstf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [sstf_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  localparam int unsigned IdxW = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [CntW-1:0] SlotCount = CntW'(MAX_REQUESTERS);
  localparam logic [IdxW-1:0] LastSlot  = IdxW'(MAX_REQUESTERS - 1);

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [MAX_REQUESTERS-1:0]         pending_q, pending_d;
  logic [sstf_pkg::CountW-1:0]       pending_cnt_q, pending_cnt_d;
  logic [sstf_pkg::CountW-1:0]       active_q, active_d;
  logic [sstf_pkg::CountW-1:0]       capacity_q, capacity_d;
  logic [sstf_pkg::TrackW-1:0]       head_q, head_d;
  logic [sstf_pkg::ReqW-1:0]         req_q, req_d;

  // Scan of the track RAM.
  logic [CntW-1:0]                   scan_cnt_q, scan_cnt_d;
  logic                              rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]                   rd_idx_q, rd_idx_d;
  logic                              found_q, found_d;
  logic [IdxW-1:0]                   best_idx_q, best_idx_d;
  logic [sstf_pkg::TrackW-1:0]       best_dist_q, best_dist_d;
  logic [sstf_pkg::TrackW-1:0]       best_trk_q, best_trk_d;

  // The latest service is held back until we know whether it is the last one.
  logic                              hold_vld_q, hold_vld_d;
  sstf_pkg::result_t                 hold_q, hold_d;

  logic                              result_valid_q, result_valid_d;
  sstf_pkg::result_t                 result_q, result_d;

  logic                              ram_we;
  logic [IdxW-1:0]                   ram_raddr;
  logic [sstf_pkg::TrackW-1:0]       ram_rdata;

  logic [IdxW-1:0]                   req_idx;
  logic                              req_ok;
  logic                              slot_busy;
  logic                              reject;
  logic [sstf_pkg::CountW-1:0]       serve_limit;
  logic                              must_serve;
  logic [sstf_pkg::TrackW-1:0]       seek_dist;

  assign req_idx   = IdxW'(in_i.requester);
  assign req_ok    = 32'(in_i.requester) < MAX_REQUESTERS;
  assign slot_busy = req_ok && pending_q[req_idx];
  assign reject    = !req_ok || (32'(in_i.track) >= TRACK_LIMIT) ||
                     (pending_cnt_q >= capacity_q) || slot_busy;

  // Serving goes on while the queue is not empty and has not dropped below
  // the smaller of the active count and the capacity.
  assign serve_limit = (active_q < capacity_q) ? active_q : capacity_q;
  assign must_serve  = (pending_cnt_q != '0) && !(pending_cnt_q < serve_limit);

  assign seek_dist = (ram_rdata > head_q) ? (ram_rdata - head_q) : (head_q - ram_rdata);

  assign ram_raddr = scan_cnt_q[IdxW-1:0];

  sstf_ram #(
    .Width(sstf_pkg::TrackW),
    .Depth(MAX_REQUESTERS)
  ) u_track_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(req_idx),
    .wdata_i(in_i.track),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d        = state_q;
    pending_d      = pending_q;
    pending_cnt_d  = pending_cnt_q;
    active_d       = active_q;
    capacity_d     = capacity_q;
    head_d         = head_q;
    req_d          = req_q;
    scan_cnt_d     = scan_cnt_q;
    rd_vld_d       = rd_vld_q;
    rd_idx_d       = rd_idx_q;
    found_d        = found_q;
    best_idx_d     = best_idx_q;
    best_dist_d    = best_dist_q;
    best_trk_d     = best_trk_q;
    hold_vld_d     = hold_vld_q;
    hold_d         = hold_q;
    result_valid_d = 1'b0;
    result_d       = result_q;
    ram_we         = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d = in_i.requester;
          if (in_i.op == sstf_pkg::OP_SUBMIT) begin
            if (reject) begin
              result_valid_d            = 1'b1;
              result_d.kind             = sstf_pkg::KIND_REJECTED;
              result_d.served_requester = in_i.requester;
              result_d.served_track     = head_q;
              result_d.last             = 1'b1;
            end else begin
              pending_d[req_idx] = 1'b1;
              pending_cnt_d      = pending_cnt_q + 1'b1;
              ram_we             = 1'b1;
              state_d            = ST_CHECK;
            end
          end else begin
            if (active_q != '0) begin
              active_d = active_q - 1'b1;
            end
            state_d = ST_CHECK;
          end
        end
      end

      ST_CHECK: begin
        if (must_serve) begin
          if (hold_vld_q) begin
            result_valid_d = 1'b1;
            result_d       = hold_q;
            result_d.last  = 1'b0;
          end
          hold_vld_d = 1'b0;
          scan_cnt_d = '0;
          rd_vld_d   = 1'b0;
          found_d    = 1'b0;
          state_d    = ST_SCAN;
        end else begin
          result_valid_d = 1'b1;
          if (hold_vld_q) begin
            result_d = hold_q;
          end else begin
            result_d.kind             = sstf_pkg::KIND_NO_SERVICE;
            result_d.served_requester = req_q;
            result_d.served_track     = head_q;
          end
          result_d.last = 1'b1;
          hold_vld_d    = 1'b0;
          state_d       = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // Issue one slot read per cycle; compare the slot whose registered read data has returned.
        if (scan_cnt_q != SlotCount) begin
          rd_vld_d   = 1'b1;
          rd_idx_d   = scan_cnt_q[IdxW-1:0];
          scan_cnt_d = scan_cnt_q + 1'b1;
        end else begin
          rd_vld_d = 1'b0;
        end
        // A strict compare keeps the lowest index on a tie.
        if (rd_vld_q && pending_q[rd_idx_q] && (!found_q || (seek_dist < best_dist_q))) begin
          found_d     = 1'b1;
          best_idx_d  = rd_idx_q;
          best_dist_d = seek_dist;
          best_trk_d  = ram_rdata;
        end
        if (rd_vld_q && (rd_idx_q == LastSlot)) begin
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (found_q) begin
          head_d                  = best_trk_q;
          pending_d[best_idx_q]   = 1'b0;
          pending_cnt_d           = pending_cnt_q - 1'b1;
          hold_vld_d              = 1'b1;
          hold_d.kind             = sstf_pkg::KIND_SERVICE;
          hold_d.served_requester = sstf_pkg::ReqW'(best_idx_q);
          hold_d.served_track     = best_trk_q;
          hold_d.last             = 1'b0;
        end else begin
          pending_cnt_d = '0;
        end
        state_d = ST_CHECK;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      unique case (sstf_pkg::cfg_reg_e'(cfg_idx_i))
        sstf_pkg::CFG_QUEUE_CAPACITY:  capacity_d = cfg_wdata_i;
        sstf_pkg::CFG_REQUESTER_TOTAL: active_d   = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      pending_q      <= '0;
      pending_cnt_q  <= '0;
      active_q       <= sstf_pkg::CountW'(16);
      capacity_q     <= sstf_pkg::CountW'(16);
      head_q         <= '0;
      scan_cnt_q     <= '0;
      rd_vld_q       <= 1'b0;
      found_q        <= 1'b0;
      hold_vld_q     <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      pending_q      <= pending_d;
      pending_cnt_q  <= pending_cnt_d;
      active_q       <= active_d;
      capacity_q     <= capacity_d;
      head_q         <= head_d;
      scan_cnt_q     <= scan_cnt_d;
      rd_vld_q       <= rd_vld_d;
      found_q        <= found_d;
      hold_vld_q     <= hold_vld_d;
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    rd_idx_q    <= rd_idx_d;
    best_idx_q  <= best_idx_d;
    best_dist_q <= best_dist_d;
    best_trk_q  <= best_trk_d;
    hold_q      <= hold_d;
    result_q    <= result_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

`ifndef ASSERT_OFF
  // The queue count always matches the number of occupied slots.
  a_count_matches_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pending_cnt_q) == $countones(pending_q))
    else $error("queue count differs from occupied slots");

  // A result beat that is not the last one is followed by more work.
  a_more_after_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last) |-> busy_o)
    else $error("non-final result while idle");

  // The head only ever moves to an accepted track.
  a_head_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(head_q) < TRACK_LIMIT || head_q == '0)
    else $error("head position beyond track limit");

  // A service beat always names a slot that the block has just released.
  a_service_frees_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && found_q) |=> !pending_q[$past(best_idx_q)])
    else $error("served slot still pending");
`endif

endmodule

[rtl/sstf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the per-slot track store; depends on nothing.
`timescale 1ns / 1ps

module sstf_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
